// ===== hdl/srd_pkg.sv =====
// Shared types and constants for the serial response deframer.
package srd_pkg;

    // Frame kinds as tagged on the output
    localparam logic [1:0] KIND_ACK       = 2'd0;
    localparam logic [1:0] KIND_BAUD_READ = 2'd1;
    localparam logic [1:0] KIND_BAUD_SET  = 2'd2;
    localparam logic [1:0] KIND_TRACE     = 2'd3;

    // Fixed header codes and trailer
    localparam logic [7:0] HDR_BAUD_READ = 8'h32;
    localparam logic [7:0] HDR_BAUD_SET  = 8'h33;
    localparam logic [7:0] HDR_TRACE     = 8'hAA;
    localparam logic [7:0] TRACE_FOOTER  = 8'hBB;

    // Frame lengths; a length counter must reach 64
    localparam int unsigned LEN_W = 7;
    localparam logic [LEN_W-1:0] LEN_BAUD_READ = 7'd6;
    localparam logic [LEN_W-1:0] LEN_BAUD_SET  = 7'd3;
    localparam logic [LEN_W-1:0] LEN_TRACE     = 7'd16;
    localparam int unsigned LEN_CAP = 64;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 6;

    // Register map, selected by paddr[2]
    localparam logic REG_ACK_CODE = 1'b0;
    localparam logic REG_ACK_LEN  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input word this cycle
        logic issue;    // read the next stored byte for output
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic frame_done;   // current input word closes a frame that is to be sent
        logic issue_ok;     // read pipeline has room
        logic issue_last;   // next read is the final byte of the frame
    } t_dp_status;

endpackage

// ===== hdl/srd_ram.sv =====
// Generic single write port RAM with registered, enabled read.
module srd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/srd_ctrl.sv =====
// Controller: alternates between taking input words and reading out a frame.
module srd_ctrl import srd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    // command decode and next state
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.issue  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_rx_valid;
                if (i_rx_valid && i_status.frame_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.issue = i_status.issue_ok;
                if (i_status.issue_ok && i_status.issue_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_rx_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/srd_datapath.sv =====
// Datapath: config registers, header decode, frame store and output stage.
module srd_datapath import srd_pkg::*; #(
    parameter int unsigned MAX_FRAME = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    // input word
    input  logic [BYTE_W-1:0] i_rx_byte,
    // control
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    // output word
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_frame_kind,
    output logic [IDX_W-1:0]  o_byte_index,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_last
);

    localparam int unsigned LIM = (MAX_FRAME < LEN_CAP) ? MAX_FRAME : LEN_CAP;
    localparam int unsigned AW  = $clog2(LIM);
    localparam logic [LEN_W-1:0] LIM_LEN = LEN_W'(LIM);

    // configuration registers
    logic [7:0] r_ack_code;
    logic [5:0] r_ack_len;
    logic       w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_code <= 8'd6;
            r_ack_len  <= 6'd32;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_ACK_CODE: r_ack_code <= pwdata[7:0];
                REG_ACK_LEN:  r_ack_len  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ACK_CODE: prdata = {24'd0, r_ack_code};
            REG_ACK_LEN:  prdata = {26'd0, r_ack_len};
            default:      prdata = 32'd0;
        endcase
    end

    // frame state
    logic             r_open;
    logic [LEN_W-1:0] r_held;
    logic [LEN_W-1:0] r_len;
    logic [1:0]       r_kind;

    // header decode, ack code checked first
    logic             w_hit;
    logic [1:0]       w_new_kind;
    logic [LEN_W-1:0] w_new_raw;
    logic [LEN_W-1:0] w_new_len;

    always_comb begin
        w_hit      = 1'b1;
        w_new_kind = KIND_ACK;
        w_new_raw  = {1'b0, r_ack_len} + LEN_W'(1);
        priority if (i_rx_byte == r_ack_code) begin
            w_new_kind = KIND_ACK;
        end else if (i_rx_byte == HDR_BAUD_READ) begin
            w_new_kind = KIND_BAUD_READ;
            w_new_raw  = LEN_BAUD_READ;
        end else if (i_rx_byte == HDR_BAUD_SET) begin
            w_new_kind = KIND_BAUD_SET;
            w_new_raw  = LEN_BAUD_SET;
        end else if (i_rx_byte == HDR_TRACE) begin
            w_new_kind = KIND_TRACE;
            w_new_raw  = LEN_TRACE;
        end else begin
            w_hit = 1'b0;
        end
        w_new_len = (w_new_raw > LIM_LEN) ? LIM_LEN : w_new_raw;
    end

    // byte intake
    logic             w_cur_open;
    logic [LEN_W-1:0] w_held;
    logic [LEN_W-1:0] w_held_n;
    logic [LEN_W-1:0] w_len;
    logic [1:0]       w_kind;
    logic             w_done;
    logic             w_bad;

    assign w_cur_open = r_open || w_hit;
    assign w_held     = r_open ? r_held : '0;
    assign w_len      = r_open ? r_len  : w_new_len;
    assign w_kind     = r_open ? r_kind : w_new_kind;
    assign w_held_n   = w_held + LEN_W'(1);
    assign w_done     = w_cur_open && (w_held_n == w_len);
    // a trace frame is 16 bytes, so its footer is the closing word itself
    assign w_bad      = (w_kind == KIND_TRACE) && (i_rx_byte != TRACE_FOOTER);

    assign o_status.frame_done = w_done && !w_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_held <= '0;
            r_len  <= '0;
            r_kind <= KIND_ACK;
        end else if (i_cmd.accept && w_cur_open) begin
            if (!r_open) begin
                r_len  <= w_new_len;
                r_kind <= w_new_kind;
            end
            if (w_done) begin
                r_open <= 1'b0;
                r_held <= '0;
            end else begin
                r_open <= 1'b1;
                r_held <= w_held_n;
            end
        end
    end

    // frame store
    logic [AW-1:0]     r_rd_idx;
    logic [BYTE_W-1:0] w_rdata;

    srd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LIM)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && w_cur_open),
        .i_waddr (w_held[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    // read pipeline: issue stage then output register
    logic             r_pend;
    logic [AW-1:0]    r_pend_idx;
    logic [1:0]       r_pend_kind;
    logic             r_pend_last;
    logic             w_load;
    logic             w_issue_last;

    assign w_issue_last = (LEN_W'(r_rd_idx) == (r_len - LEN_W'(1)));
    assign w_load       = r_pend && (!o_out_valid || i_out_ready);

    assign o_status.issue_ok   = !r_pend || w_load;
    assign o_status.issue_last = w_issue_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_pend      <= 1'b1;
                r_pend_idx  <= r_rd_idx;
                r_pend_kind <= r_kind;
                r_pend_last <= w_issue_last;
                r_rd_idx    <= w_issue_last ? '0 : r_rd_idx + AW'(1);
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
        end
    end

    // output register
    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [IDX_W-1:0]  r_out_idx;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_kind <= r_pend_kind;
            r_out_idx  <= IDX_W'(r_pend_idx);
            r_out_data <= w_rdata;
            r_out_last <= r_pend_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_kind = r_out_kind;
    assign o_byte_index = r_out_idx;
    assign o_data_byte  = r_out_data;
    assign o_last       = r_out_last;

endmodule

// ===== hdl/serial_response_deframer_top.sv =====
// Top level of the serial response deframer.
//
//  channel  direction  handshake                   payload
//  rx       in         i_rx_valid / o_rx_ready     i_rx_byte
//  out      out        o_out_valid / i_out_ready   o_frame_kind, o_byte_index,
//                                                  o_data_byte, o_last
//  cfg      in         psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// An input word is taken when i_rx_valid and o_rx_ready are both high. When a word
// completes a frame, intake pauses while the frame store's single read port is read
// one entry per cycle while the output does not stall; output stalls lengthen the pause.
// The last words of a frame may still sit in the output stage when intake resumes.
// Reset is synchronous, active low; the frame store needs no clearing pass.
module serial_response_deframer_top import srd_pkg::*; #(
    parameter int unsigned MAX_FRAME = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input words
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // output words
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_frame_kind,
    output logic [IDX_W-1:0]  o_byte_index,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_last
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    assign pready = 1'b1;

    srd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    srd_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .i_rx_byte    (i_rx_byte),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame_kind (o_frame_kind),
        .o_byte_index (o_byte_index),
        .o_data_byte  (o_data_byte),
        .o_last       (o_last)
    );

    // intake and readout never share a cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.accept && w_cmd.issue))
        else $error("intake and readout in the same cycle");

    // a trace frame that goes out ends on its footer at index 15
    a_trace_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last && (o_frame_kind == KIND_TRACE)) |->
        ((o_data_byte == TRACE_FOOTER) && (o_byte_index == IDX_W'(15))))
        else $error("trace frame sent without footer");

    // the header of a trace frame carries its own code
    a_trace_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_byte_index == '0) && (o_frame_kind == KIND_TRACE)) |->
        (o_data_byte == HDR_TRACE))
        else $error("trace frame header mismatch");

    // a baud set reply is three words long
    a_baud_set_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last && (o_frame_kind == KIND_BAUD_SET)) |->
        (o_byte_index == IDX_W'(2)))
        else $error("baud set reply length mismatch");

endmodule
